// ===== src/bsqa_pkg.sv =====
package bsqa_pkg;

  localparam int HANDLE_W    = 32;
  localparam int SIZE_W      = 16;
  localparam int LIMIT_W     = 6;
  localparam int DRAIN_W     = 6;
  localparam int DEPTH_OUT_W = 6;
  localparam int BYTES_OUT_W = 21;
  localparam int OVF_W       = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_DRAIN    = 2'd1,
    CMD_MARK     = 2'd2,
    CMD_SNAPSHOT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_PUSH_ACK = 2'd0,
    KIND_DRAIN    = 2'd1,
    KIND_MARK_ACK = 2'd2,
    KIND_STATS    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } desc_t;

endpackage

// ===== src/bounded_send_queue_with_accounting.sv =====
// Channel | Handshake                 | Payload
// input   | start, busy (accept on start & !busy) | in_command .. in_drain_max
// result  | out_strobe, one cycle, no backpressure | out_result_kind .. out_overflow_total
// config  | cfg_wr_en                 | cfg_wr_data (pending_limit)
//
// Push, mark and snapshot: result is registered out of S_EXEC, or out of S_PEAK for a stored push.
// Drain: per descriptor a memory read (S_RD), then a pop through the shared
// byte adder (S_POP); an empty drain answers from S_EXEC.
// Busy stays high from accept until the final beat (out_last) is driven.
// rst_n is synchronous; the descriptor memory is not cleared and needs no sweep.
module bounded_send_queue_with_accounting
  import bsqa_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_command,
  input  logic [HANDLE_W-1:0]    in_buffer_handle,
  input  logic [SIZE_W-1:0]      in_buffer_size,
  input  logic                   in_buffer_present,
  input  logic [DRAIN_W-1:0]     in_drain_max,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_W-1:0]     cfg_wr_data,
  output logic                   out_strobe,
  output logic [1:0]             out_result_kind,
  output logic                   out_first_push,
  output logic                   out_overflowed,
  output logic [DEPTH_OUT_W-1:0] out_depth_now,
  output logic [BYTES_OUT_W-1:0] out_bytes_now,
  output logic [HANDLE_W-1:0]    out_handle,
  output logic [SIZE_W-1:0]      out_size,
  output logic                   out_valid,
  output logic                   out_last,
  output logic [DEPTH_OUT_W-1:0] out_depth_peak,
  output logic [BYTES_OUT_W-1:0] out_bytes_peak,
  output logic [OVF_W-1:0]       out_overflow_total
);

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int CMP_W  = 8;
  localparam int BYTE_W = SIZE_W + CNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_PEAK = 5'b00100,
    S_RD   = 5'b01000,
    S_POP  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [SIZE_W-1:0]   size_r;
  logic [DRAIN_W-1:0]  drain_max_r;
  logic                first_r, first_nxt;
  logic [LIMIT_W-1:0]  limit_r;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    remain_r, remain_nxt;
  logic [BYTE_W-1:0]   bytes_r, bytes_nxt;
  logic [CNT_W-1:0]    peak_cnt_r, peak_cnt_nxt;
  logic [BYTE_W-1:0]   peak_bytes_r, peak_bytes_nxt;
  logic [OVF_W-1:0]    rej_r, rej_nxt;
  logic                reg_flag_r, reg_flag_nxt;

  logic                   strobe_r, strobe_nxt;
  kind_t                  kind_r, kind_nxt;
  logic                   o_first_r, o_first_nxt;
  logic                   o_ovf_r, o_ovf_nxt;
  logic [DEPTH_OUT_W-1:0] o_depth_r, o_depth_nxt;
  logic [BYTES_OUT_W-1:0] o_bytes_r, o_bytes_nxt;
  logic [HANDLE_W-1:0]    o_handle_r, o_handle_nxt;
  logic [SIZE_W-1:0]      o_size_r, o_size_nxt;
  logic                   o_valid_r, o_valid_nxt;
  logic                   o_last_r, o_last_nxt;
  logic [DEPTH_OUT_W-1:0] o_dpeak_r, o_dpeak_nxt;
  logic [BYTES_OUT_W-1:0] o_bpeak_r, o_bpeak_nxt;
  logic [OVF_W-1:0]       o_ovtot_r, o_ovtot_nxt;

  logic              accept;
  logic [CMP_W-1:0]  limit_eff;
  logic              full;
  logic [SUM_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  head_inc;
  logic              drain_all;
  logic              mem_we;
  logic              mem_re;
  desc_t             mem_wdata;
  desc_t             mem_rdata;
  logic              alu_sub;
  logic [BYTE_W-1:0] alu_b;
  logic [BYTE_W-1:0] alu_res;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign limit_eff = (CMP_W'(limit_r) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
                                                             : CMP_W'(limit_r);
  assign full      = CMP_W'(count_r) >= limit_eff;

  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                                                      : IDX_W'(tail_sum);
  assign head_inc = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  assign drain_all = (drain_max_r == '0) || (CMP_W'(drain_max_r) >= CMP_W'(count_r));

  // shared byte adder: add on push, subtract on pop
  assign alu_sub = (state_r == S_POP);
  assign alu_b   = alu_sub ? BYTE_W'(mem_rdata.size) : BYTE_W'(size_r);
  assign alu_res = alu_sub ? bytes_r - alu_b : bytes_r + alu_b;

  assign mem_wdata.handle = handle_r;
  assign mem_wdata.size   = size_r;

  bsqa_desc_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (tail_idx),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (head_r),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    bytes_nxt      = bytes_r;
    peak_cnt_nxt   = peak_cnt_r;
    peak_bytes_nxt = peak_bytes_r;
    rej_nxt        = rej_r;
    reg_flag_nxt   = reg_flag_r;
    first_nxt      = first_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    strobe_nxt   = 1'b0;
    kind_nxt     = KIND_PUSH_ACK;
    o_first_nxt  = 1'b0;
    o_ovf_nxt    = 1'b0;
    o_depth_nxt  = DEPTH_OUT_W'(count_r);
    o_bytes_nxt  = BYTES_OUT_W'(bytes_r);
    o_handle_nxt = '0;
    o_size_nxt   = '0;
    o_valid_nxt  = 1'b0;
    o_last_nxt   = 1'b0;
    o_dpeak_nxt  = '0;
    o_bpeak_nxt  = '0;
    o_ovtot_nxt  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_r)
          CMD_PUSH: begin
            if (full) begin
              if (rej_r != '1) begin
                rej_nxt = rej_r + 1'b1;
              end
              strobe_nxt = 1'b1;
              kind_nxt   = KIND_PUSH_ACK;
              o_ovf_nxt  = 1'b1;
              o_last_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              mem_we       = 1'b1;
              count_nxt    = count_r + 1'b1;
              bytes_nxt    = alu_res;
              first_nxt    = !reg_flag_r;
              reg_flag_nxt = 1'b1;
              state_nxt    = S_PEAK;
            end
          end
          CMD_DRAIN: begin
            if (count_r == '0) begin
              strobe_nxt = 1'b1;
              kind_nxt   = KIND_DRAIN;
              o_last_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              remain_nxt = drain_all ? count_r : CNT_W'(drain_max_r);
              state_nxt  = S_RD;
            end
          end
          CMD_MARK: begin
            if (count_r == '0) begin
              reg_flag_nxt = 1'b0;
            end
            strobe_nxt = 1'b1;
            kind_nxt   = KIND_MARK_ACK;
            o_last_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
          CMD_SNAPSHOT: begin
            strobe_nxt  = 1'b1;
            kind_nxt    = KIND_STATS;
            o_dpeak_nxt = DEPTH_OUT_W'(peak_cnt_r);
            o_bpeak_nxt = BYTES_OUT_W'(peak_bytes_r);
            o_ovtot_nxt = rej_r;
            o_last_nxt  = 1'b1;
            state_nxt   = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_PEAK: begin
        if (count_r > peak_cnt_r) begin
          peak_cnt_nxt = count_r;
        end
        if (bytes_r > peak_bytes_r) begin
          peak_bytes_nxt = bytes_r;
        end
        strobe_nxt  = 1'b1;
        kind_nxt    = KIND_PUSH_ACK;
        o_first_nxt = first_r;
        o_last_nxt  = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        head_nxt     = head_inc;
        count_nxt    = count_r - 1'b1;
        bytes_nxt    = alu_res;
        remain_nxt   = remain_r - 1'b1;
        strobe_nxt   = 1'b1;
        kind_nxt     = KIND_DRAIN;
        o_depth_nxt  = DEPTH_OUT_W'(count_nxt);
        o_bytes_nxt  = BYTES_OUT_W'(alu_res);
        o_handle_nxt = mem_rdata.handle;
        o_size_nxt   = mem_rdata.size;
        o_valid_nxt  = 1'b1;
        o_last_nxt   = (remain_r == CNT_W'(1));
        state_nxt    = (remain_r == CNT_W'(1)) ? S_IDLE : S_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      limit_r      <= LIMIT_RESET;
      head_r       <= '0;
      count_r      <= '0;
      remain_r     <= '0;
      bytes_r      <= '0;
      peak_cnt_r   <= '0;
      peak_bytes_r <= '0;
      rej_r        <= '0;
      reg_flag_r   <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      remain_r     <= remain_nxt;
      bytes_r      <= bytes_nxt;
      peak_cnt_r   <= peak_cnt_nxt;
      peak_bytes_r <= peak_bytes_nxt;
      rej_r        <= rej_nxt;
      reg_flag_r   <= reg_flag_nxt;
      strobe_r     <= strobe_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= cmd_t'(in_command);
      handle_r    <= in_buffer_present ? in_buffer_handle : '0;
      size_r      <= in_buffer_present ? in_buffer_size : '0;
      drain_max_r <= in_drain_max;
    end
    first_r    <= first_nxt;
    kind_r     <= kind_nxt;
    o_first_r  <= o_first_nxt;
    o_ovf_r    <= o_ovf_nxt;
    o_depth_r  <= o_depth_nxt;
    o_bytes_r  <= o_bytes_nxt;
    o_handle_r <= o_handle_nxt;
    o_size_r   <= o_size_nxt;
    o_valid_r  <= o_valid_nxt;
    o_last_r   <= o_last_nxt;
    o_dpeak_r  <= o_dpeak_nxt;
    o_bpeak_r  <= o_bpeak_nxt;
    o_ovtot_r  <= o_ovtot_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_result_kind    = kind_r;
  assign out_first_push     = o_first_r;
  assign out_overflowed     = o_ovf_r;
  assign out_depth_now      = o_depth_r;
  assign out_bytes_now      = o_bytes_r;
  assign out_handle         = o_handle_r;
  assign out_size           = o_size_r;
  assign out_valid          = o_valid_r;
  assign out_last           = o_last_r;
  assign out_depth_peak     = o_dpeak_r;
  assign out_bytes_peak     = o_bpeak_r;
  assign out_overflow_total = o_ovtot_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(QUEUE_DEPTH))
    else $error("descriptor count above capacity");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (bytes_r == '0))
    else $error("byte total nonzero with empty queue");

  // peaks catch up in S_PEAK, after the push has updated count and bytes
  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PEAK) |-> ((peak_cnt_r >= count_r) && (peak_bytes_r >= bytes_r)))
    else $error("peak below current value");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && o_last_r) |-> (state_r == S_IDLE))
    else $error("final beat while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted command did not raise busy");
`endif

endmodule

// ===== src/bsqa_desc_mem.sv =====
module bsqa_desc_mem
  import bsqa_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  desc_t                                 wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output desc_t                                 rd_data
);

  desc_t mem [DEPTH];
  desc_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
